>>> rtl/core/differential_drive_odometry_defines.svh
// Assertion macros for the checker of the odometry block
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_DEFINES_SVH

// Clocked property, off while reset is asserted
`define DDO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// A stalled, valid channel keeps its payload
`define DDO_ASSERT_HOLD(lbl, vld, stl, sig) \
  `DDO_ASSERT(lbl, (vld && stl) |=> $stable(sig), "payload changed while stalled")

`endif

>>> rtl/core/ddo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ddo_pkg;

  localparam int EncBits     = 16;
  localparam int CordicSteps = 16;

  localparam int DiffW  = EncBits + 2;
  localparam int SumW   = EncBits + 3;
  localparam int MagW   = EncBits + 1;
  localparam int MulAW  = (MagW > 32) ? MagW : 32;
  localparam int ProdW  = MulAW + 32;
  localparam int CntW   = (CordicSteps > 1) ? $clog2(CordicSteps) : 1;
  localparam int CorW   = 34;
  localparam int CfgIdxW = 1;

  localparam longint EncMod  = longint'(1) << EncBits;
  localparam longint WrapLim = (EncMod * 60000) >>> 16;

  localparam logic signed [DiffW-1:0] WrapLimS = DiffW'(WrapLim);
  localparam logic signed [DiffW-1:0] EncModS  = DiffW'(EncMod);

  localparam logic signed [CorW-1:0] CordicX0 = CorW'(652032874);
  localparam logic signed [CorW-1:0] QuarterTurn = CorW'(64'h4000_0000);
  localparam logic signed [CorW-1:0] HalfTurn    = CorW'(64'h8000_0000);

  localparam logic [46:0] TravelSat = 47'h7FFF_FFFF_FFFF;

  typedef enum logic [CfgIdxW-1:0] {
    REG_METERS_PER_TICK  = 1'b0,
    REG_HEADING_PER_TICK = 1'b1
  } ddo_reg_e;

  typedef enum logic [2:0] {
    MUL_HEAD,
    MUL_TRAV,
    MUL_X_HI,
    MUL_X_LO,
    MUL_Y_HI,
    MUL_Y_LO
  } ddo_mul_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_MUL_H,
    S_MUL_T,
    S_COR_INIT,
    S_COR_STEP,
    S_X_HI,
    S_X_LO,
    S_X_ADD,
    S_Y_LO,
    S_Y_ADD,
    S_OUT
  } ddo_state_e;

  typedef struct packed {
    logic            load_in;
    logic            take_diff;
    logic            mul_en;
    ddo_mul_e        mul_sel;
    logic            head_upd;
    logic            trav_load;
    logic            cor_init;
    logic            cor_step;
    logic [CntW-1:0] cor_idx;
    logic            part_hold;
    logic            acc_x;
    logic            acc_y;
    logic            out_load;
  } ddo_cmd_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10680862;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Count difference with wrap correction
  function automatic logic signed [DiffW-1:0] wrap_diff(input logic [EncBits-1:0] now,
                                                         input logic [EncBits-1:0] prev);
    logic signed [DiffW-1:0] d;
    d = $signed({2'b00, now}) - $signed({2'b00, prev});
    if (d < -WrapLimS) begin
      d = d + EncModS;
    end else if (d > WrapLimS) begin
      d = d - EncModS;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ddo_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

module ddo_cordic import ddo_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            init_i,
  input  wire logic            step_i,
  input  wire logic [CntW-1:0] idx_i,
  input  wire logic [31:0]     angle_i,
  output logic [31:0]          cos_mag_o,
  output logic                 cos_neg_o,
  output logic [31:0]          sin_mag_o,
  output logic                 sin_neg_o
);

  logic signed [CorW-1:0] x_q, x_d;
  logic signed [CorW-1:0] y_q, y_d;
  logic signed [CorW-1:0] z_q, z_d;
  logic                   flip_q, flip_d;

  logic signed [CorW-1:0] ang_s;
  logic signed [CorW-1:0] xs, ys, at;
  logic signed [CorW-1:0] x_abs, y_abs;

  assign ang_s = {{(CorW-32){angle_i[31]}}, angle_i};
  assign xs    = x_q >>> idx_i;
  assign ys    = y_q >>> idx_i;
  assign at    = CorW'(atan_lut(5'(idx_i)));

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    flip_d = flip_q;
    if (init_i) begin
      // fold into the right half-plane, sign restored at the end
      x_d    = CordicX0;
      y_d    = '0;
      flip_d = 1'b0;
      z_d    = ang_s;
      if (ang_s > QuarterTurn) begin
        z_d    = ang_s - HalfTurn;
        flip_d = 1'b1;
      end else if (ang_s < -QuarterTurn) begin
        z_d    = ang_s + HalfTurn;
        flip_d = 1'b1;
      end
    end else if (step_i) begin
      if (!z_q[CorW-1]) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - at;
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + at;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    flip_q <= flip_d;
  end

  assign x_abs     = x_q[CorW-1] ? -x_q : x_q;
  assign y_abs     = y_q[CorW-1] ? -y_q : y_q;
  assign cos_mag_o = x_abs[31:0];
  assign sin_mag_o = y_abs[31:0];
  assign cos_neg_o = x_q[CorW-1] ^ flip_q;
  assign sin_neg_o = y_q[CorW-1] ^ flip_q;

endmodule

`default_nettype wire

>>> rtl/core/ddo_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module ddo_dpath import ddo_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ddo_cmd_t           cmd_i,
  output logic                    init_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic [EncBits-1:0] enc_left_i,
  input  wire logic [EncBits-1:0] enc_right_i,
  output logic signed [47:0]      pos_x_o,
  output logic signed [47:0]      pos_y_o,
  output logic [31:0]             heading_o
);

  logic [31:0]        mpt_q;
  logic [23:0]        hpt_q;
  logic               init_q;
  logic [EncBits-1:0] last_l_q, last_r_q;
  logic [EncBits-1:0] enc_l_q, enc_r_q;
  logic [31:0]        heading_q;
  logic [47:0]        x_acc_q, y_acc_q;

  logic [MagW-1:0]    dd_mag_q, sum_mag_q;
  logic               dd_neg_q, sum_neg_q;
  logic [ProdW-1:0]   prod_q;
  logic [62:0]        part_q;
  logic [46:0]        tm_q;

  logic [47:0]        pos_x_q, pos_y_q;
  logic [31:0]        heading_out_q;

  logic signed [DiffW-1:0] dl, dr;
  logic signed [SumW-1:0]  dd, sum;
  logic [SumW-1:0]         dd_abs, sum_abs;
  logic [MulAW-1:0]        mul_a;
  logic [31:0]             mul_b;
  logic [ProdW-1:0]        prod_c;
  logic [31:0]             head_step;
  logic [48:0]             lo_sum;
  logic [49:0]             r_c;
  logic [47:0]             r48;
  logic                    neg_sel;
  logic [47:0]             acc_step;

  logic [31:0] cos_mag, sin_mag;
  logic        cos_neg, sin_neg;

  ddo_cordic u_cordic (
    .clk_i     (clk_i),
    .init_i    (cmd_i.cor_init),
    .step_i    (cmd_i.cor_step),
    .idx_i     (cmd_i.cor_idx),
    .angle_i   (heading_q),
    .cos_mag_o (cos_mag),
    .cos_neg_o (cos_neg),
    .sin_mag_o (sin_mag),
    .sin_neg_o (sin_neg)
  );

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mpt_q <= 32'd365072;
      hpt_q <= 24'd252000;
    end else if (cfg_we_i) begin
      case (ddo_reg_e'(cfg_idx_i))
        REG_METERS_PER_TICK:  mpt_q <= cfg_data_i;
        REG_HEADING_PER_TICK: hpt_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // count differences
  assign dl      = wrap_diff(enc_l_q, last_l_q);
  assign dr      = wrap_diff(enc_r_q, last_r_q);
  assign dd      = SumW'(dr) - SumW'(dl);
  assign sum     = SumW'(dr) + SumW'(dl);
  assign dd_abs  = dd[SumW-1] ? SumW'(-dd) : SumW'(dd);
  assign sum_abs = sum[SumW-1] ? SumW'(-sum) : SumW'(sum);

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_HEAD: begin
        mul_a = MulAW'(dd_mag_q);
        mul_b = 32'(hpt_q);
      end
      MUL_TRAV: begin
        mul_a = MulAW'(sum_mag_q);
        mul_b = mpt_q;
      end
      MUL_X_HI: begin
        mul_a = MulAW'(tm_q[46:16]);
        mul_b = cos_mag;
      end
      MUL_X_LO: begin
        mul_a = MulAW'(tm_q[15:0]);
        mul_b = cos_mag;
      end
      MUL_Y_HI: begin
        mul_a = MulAW'(tm_q[46:16]);
        mul_b = sin_mag;
      end
      MUL_Y_LO: begin
        mul_a = MulAW'(tm_q[15:0]);
        mul_b = sin_mag;
      end
      default: ;
    endcase
  end

  assign prod_c    = ProdW'(mul_a) * ProdW'(mul_b);
  assign head_step = dd_neg_q ? (32'd0 - prod_q[31:0]) : prod_q[31:0];

  // (travel * trig) >> 30 from high part (part_q) and low part (prod_q)
  assign lo_sum   = 49'({part_q[13:0], 16'h0000}) + 49'(prod_q[47:0]);
  assign r_c      = 50'(part_q[62:14]) + 50'(lo_sum[48:30]);
  assign r48      = r_c[47:0];
  assign neg_sel  = sum_neg_q ^ (cmd_i.acc_x ? cos_neg : sin_neg);
  assign acc_step = neg_sel ? (48'd0 - r48) : r48;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q    <= 1'b0;
      last_l_q  <= '0;
      last_r_q  <= '0;
      heading_q <= '0;
      x_acc_q   <= '0;
      y_acc_q   <= '0;
    end else begin
      if (cmd_i.take_diff) begin
        init_q   <= 1'b1;
        last_l_q <= enc_l_q;
        last_r_q <= enc_r_q;
      end
      if (cmd_i.head_upd) begin
        heading_q <= heading_q + head_step;
      end
      if (cmd_i.acc_x) begin
        x_acc_q <= x_acc_q + acc_step;
      end
      if (cmd_i.acc_y) begin
        y_acc_q <= y_acc_q + acc_step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      enc_l_q <= enc_left_i;
      enc_r_q <= enc_right_i;
    end
    if (cmd_i.take_diff) begin
      dd_mag_q  <= dd_abs[MagW-1:0];
      dd_neg_q  <= dd[SumW-1];
      sum_mag_q <= sum_abs[MagW-1:0];
      sum_neg_q <= sum[SumW-1];
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_c;
    end
    if (cmd_i.part_hold) begin
      part_q <= prod_q[62:0];
    end
    if (cmd_i.trav_load) begin
      // saturate once the product no longer fits 48 bits
      if (|prod_q[ProdW-1:48]) begin
        tm_q <= TravelSat;
      end else begin
        tm_q <= prod_q[47:1];
      end
    end
    if (cmd_i.out_load) begin
      pos_x_q       <= x_acc_q;
      pos_y_q       <= y_acc_q;
      heading_out_q <= heading_q;
    end
  end

  assign init_o    = init_q;
  assign pos_x_o   = $signed(pos_x_q);
  assign pos_y_o   = $signed(pos_y_q);
  assign heading_o = heading_out_q;

endmodule

`default_nettype wire

>>> rtl/core/ddo_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ddo_ctrl import ddo_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  input  wire logic init_i,
  output ddo_cmd_t  cmd_o
);

  ddo_state_e      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_DIFF;
      S_DIFF:     state_d = init_i ? S_MUL_H : S_OUT;
      S_MUL_H:    state_d = S_MUL_T;
      S_MUL_T:    state_d = S_COR_INIT;
      S_COR_INIT: begin
        state_d = S_COR_STEP;
        cnt_d   = '0;
      end
      S_COR_STEP: begin
        if (cnt_q == CntW'(CordicSteps - 1)) begin
          state_d = S_X_HI;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_X_HI:     state_d = S_X_LO;
      S_X_LO:     state_d = S_X_ADD;
      S_X_ADD:    state_d = S_Y_LO;
      S_Y_LO:     state_d = S_Y_ADD;
      S_Y_ADD:    state_d = S_OUT;
      S_OUT:      if (out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_HEAD;
    cmd_o.cor_idx = cnt_q;
    in_stall_o    = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.load_in = in_valid_i;
      end
      S_DIFF:     cmd_o.take_diff = 1'b1;
      S_MUL_H: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_HEAD;
      end
      S_MUL_T: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_TRAV;
        cmd_o.head_upd = 1'b1;
      end
      S_COR_INIT: begin
        cmd_o.trav_load = 1'b1;
        cmd_o.cor_init  = 1'b1;
      end
      S_COR_STEP: cmd_o.cor_step = 1'b1;
      S_X_HI: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_X_HI;
      end
      S_X_LO: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = MUL_X_LO;
        cmd_o.part_hold = 1'b1;
      end
      S_X_ADD: begin
        cmd_o.acc_x   = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_Y_HI;
      end
      S_Y_LO: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = MUL_Y_LO;
        cmd_o.part_hold = 1'b1;
      end
      S_Y_ADD:    cmd_o.acc_y = 1'b1;
      S_OUT:      cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  assign out_valid_d = cmd_o.out_load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/core/differential_drive_odometry.sv
`timescale 1ns / 1ps
`default_nettype none
// Wheel odometry: one pose result per encoder item, one item in flight at a time.
// The first item after reset only latches its counts; later ones pass the shared multiplier
// and the 16-step iterative CORDIC, and no new item is taken before the last one is through.
// The result register frees the input side; a new item waits only while one is in work.
// rst_ni is asynchronous, active low: pose, counts and flags clear, registers take defaults.

module differential_drive_odometry import ddo_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [EncBits-1:0] enc_left_i,
  input  wire logic [EncBits-1:0] enc_right_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [47:0]      pos_x_o,
  output logic signed [47:0]      pos_y_o,
  output logic [31:0]             heading_o
);

  ddo_cmd_t cmd;
  logic     init;

  ddo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .init_i      (init),
    .cmd_o       (cmd)
  );

  ddo_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .init_o      (init),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .enc_left_i  (enc_left_i),
    .enc_right_i (enc_right_i),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .heading_o   (heading_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/ddo_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "differential_drive_odometry_defines.svh"

module ddo_checker import ddo_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [47:0] pos_x_o,
  input wire logic signed [47:0] pos_y_o,
  input wire logic [31:0]        heading_o
);

  `DDO_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> out_valid_o, "result item dropped")
  `DDO_ASSERT_HOLD(a_pose_stable, out_valid_o, out_stall_i, ({pos_x_o, pos_y_o, heading_o}))
  // one item at a time: busy right after taking an item
  `DDO_ASSERT(a_busy_after_take, (in_valid_i && !in_stall_o) |=> in_stall_o, "second item taken")
  // a result only appears at the end of work on an item
  `DDO_ASSERT(a_result_from_work, $rose(out_valid_o) |-> $past(in_stall_o), "result while idle")

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .pos_x_o     (pos_x_o),
  .pos_y_o     (pos_y_o),
  .heading_o   (heading_o)
);

`default_nettype wire

>>> dv/odometry_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the odometry block, keeps its own pose and
// register copies, and compares every result with the oldest predicted pose.
module odometry_checker import ddo_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [EncBits-1:0] enc_left_i,
  input  logic [EncBits-1:0] enc_right_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [47:0]        pos_x_i,
  input  logic [47:0]        pos_y_i,
  input  logic [31:0]        heading_i,
  output int                 pending_o,
  output int                 errors_o
);

  localparam logic [31:0] MptDefault = 32'd365072;
  localparam logic [23:0] HptDefault = 24'd252000;
  localparam longint WrapSpan    = ((longint'(1) << EncBits) * 60000) / 65536;
  localparam longint EncSpan     = longint'(1) << EncBits;
  localparam longint StartX      = 64'sd652032874;
  localparam longint QuarterTurn = 64'sh4000_0000;
  localparam longint HalfTurn    = 64'sh8000_0000;
  localparam longint FullTurn    = 64'sh1_0000_0000;
  localparam logic [63:0] TravelMax = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] TravelSat = 64'h7FFF_FFFF_FFFF;
  localparam int ReportLimit = 10;

  // arctan(2^-i) in 2^-32 turn units
  localparam int unsigned AtanTurn [0:31] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0
  };

  typedef struct packed {
    logic [47:0] x;
    logic [47:0] y;
    logic [31:0] hdg;
  } pose_t;

  pose_t pose_q[$];

  logic [31:0]        mpt;
  logic [23:0]        hpt;
  logic               seen_first;
  logic [EncBits-1:0] prev_l;
  logic [EncBits-1:0] prev_r;
  logic [31:0]        hdg_acc;
  logic [47:0]        x_acc;
  logic [47:0]        y_acc;
  int                 errors;

  function automatic longint tick_delta(input logic [EncBits-1:0] now,
                                        input logic [EncBits-1:0] prev);
    longint d;
    d = longint'(now) - longint'(prev);
    if (d < -WrapSpan) begin
      d = d + EncSpan;
    end else if (d > WrapSpan) begin
      d = d - EncSpan;
    end
    return d;
  endfunction

  // cos/sin of a binary angle, Q2.30
  function automatic void rotate(input logic [31:0] ang, output longint c, output longint s);
    longint z, x, y, xs, ys;
    bit flip;
    z = longint'(ang);
    if (z >= HalfTurn) z = z - FullTurn;
    flip = 1'b0;
    if (z > QuarterTurn) begin
      z = z - HalfTurn;
      flip = 1'b1;
    end else if (z < -QuarterTurn) begin
      z = z + HalfTurn;
      flip = 1'b1;
    end
    x = StartX;
    y = 0;
    for (int i = 0; i < CordicSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(AtanTurn[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(AtanTurn[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // (d * k) / 2^30 with the magnitude truncated
  function automatic longint scale_q30(input longint d, input longint k);
    logic [63:0] dm, km;
    logic [95:0] p;
    logic [63:0] r;
    bit neg;
    neg = (d < 0) != (k < 0);
    dm = (d < 0) ? 64'(-d) : 64'(d);
    km = (k < 0) ? 64'(-k) : 64'(k);
    p = 96'(dm) * 96'(km);
    r = 64'(p >> 30);
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic void advance_pose(input logic [EncBits-1:0] l,
                                       input logic [EncBits-1:0] r);
    longint dl, dr, sum, travel, c, s;
    logic [63:0] sm, prod, tm, turn;
    if (!seen_first) begin
      seen_first = 1'b1;
    end else begin
      dl = tick_delta(l, prev_l);
      dr = tick_delta(r, prev_r);
      sum = dl + dr;
      sm = (sum < 0) ? 64'(-sum) : 64'(sum);
      turn = 64'((dr - dl) * longint'(hpt));
      hdg_acc = hdg_acc + turn[31:0];
      prod = sm * 64'(mpt);
      tm = (prod > TravelMax) ? TravelSat : (prod >> 1);
      travel = (sum < 0) ? -longint'(tm) : longint'(tm);
      rotate(hdg_acc, c, s);
      x_acc = x_acc + 48'(scale_q30(travel, c));
      y_acc = y_acc + 48'(scale_q30(travel, s));
    end
    prev_l = l;
    prev_r = r;
  endfunction

  function automatic void flag_field(input string field, input logic [63:0] want,
                                     input logic [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= ReportLimit) begin
        $display("%t %s: expected %h, got %h", $realtime, field, want, got);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pose_t want;
    if (!rst_ni) begin
      mpt = MptDefault;
      hpt = HptDefault;
      seen_first = 1'b0;
      prev_l = '0;
      prev_r = '0;
      hdg_acc = '0;
      x_acc = '0;
      y_acc = '0;
      errors = 0;
      pose_q.delete();
      pending_o <= 0;
      errors_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_METERS_PER_TICK:  mpt = cfg_data_i;
          REG_HEADING_PER_TICK: hpt = cfg_data_i[23:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (pose_q.size() == 0) begin
          errors++;
          if (errors <= ReportLimit) begin
            $display("%t pose item with none expected: x %h y %h heading %h",
                     $realtime, pos_x_i, pos_y_i, heading_i);
          end
        end else begin
          want = pose_q.pop_front();
          flag_field("pos_x", 64'(want.x), 64'(pos_x_i));
          flag_field("pos_y", 64'(want.y), 64'(pos_y_i));
          flag_field("heading", 64'(want.hdg), 64'(heading_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        advance_pose(enc_left_i, enc_right_i);
        pose_q.insert(pose_q.size(), pose_t'{x_acc, y_acc, hdg_acc});
      end
      pending_o <= pose_q.size();
      errors_o <= errors;
    end
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ddo_pkg::*;

  localparam int CycleLimit    = 600000;
  localparam int DrainCycles   = 40;
  localparam int HoldCycles    = 600;
  localparam int HoldAfter     = 400;
  localparam int RandomPhases  = 8;
  localparam int PhaseItems    = 230;
  localparam logic [31:0] MptDefault = 32'd365072;
  localparam logic [31:0] HptDefault = 32'd252000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  ddo_reg_e           cfg_idx = REG_METERS_PER_TICK;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [EncBits-1:0] enc_left = '0;
  logic [EncBits-1:0] enc_right = '0;
  logic               out_valid;
  logic               rx_stall = 1'b0;
  logic               long_hold = 1'b0;
  logic               out_stall;
  logic signed [47:0] pos_x;
  logic signed [47:0] pos_y;
  logic [31:0]        heading;
  int                 pending;
  int                 errors;
  int                 cycles = 0;
  int                 items_sent = 0;
  int                 tx_max = 0;
  int                 rx_max = 0;
  logic [EncBits-1:0] cur_l = '0;
  logic [EncBits-1:0] cur_r = '0;

  assign out_stall = rx_stall | long_hold;

  differential_drive_odometry dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .enc_left_i  (enc_left),
    .enc_right_i (enc_right),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .pos_x_o     (pos_x),
    .pos_y_o     (pos_y),
    .heading_o   (heading)
  );

  odometry_checker pose_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .enc_left_i  (enc_left),
    .enc_right_i (enc_right),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .pos_x_i     (pos_x),
    .pos_y_i     (pos_y),
    .heading_i   (heading),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_counts(input logic [EncBits-1:0] l, input logic [EncBits-1:0] r);
    int gap;
    // switch between idling and back-to-back stretches now and then
    if (items_sent % 64 == 0) tx_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
    gap = $urandom_range(0, tx_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    enc_left <= l;
    enc_right <= r;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    items_sent++;
    cur_l = l;
    cur_r = r;
  endtask

  // Mostly small wheel motion from the last counts, some jumps near the wrap
  // threshold and some raw noise.
  task automatic push_random();
    logic [EncBits-1:0] l, r;
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 75) begin
      l = cur_l + EncBits'($urandom_range(0, 600)) - EncBits'(300);
      r = cur_r + EncBits'($urandom_range(0, 600)) - EncBits'(300);
    end else if (kind < 90) begin
      l = cur_l + EncBits'($urandom_range(0, 120000)) - EncBits'(60000);
      r = cur_r + EncBits'($urandom_range(0, 120000)) - EncBits'(60000);
    end else begin
      l = EncBits'($urandom);
      r = EncBits'($urandom);
    end
    push_counts(l, r);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [31:0] mpt, input logic [31:0] hpt);
    cfg_we <= 1'b1;
    cfg_idx <= REG_METERS_PER_TICK;
    cfg_data <= mpt;
    @(posedge clk_i);
    cfg_idx <= REG_HEADING_PER_TICK;
    cfg_data <= hpt;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : rx_side
    int gap;
    int taken;
    taken = 0;
    forever begin
      if (taken % 64 == 0) rx_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
      gap = $urandom_range(0, rx_max);
      if (gap > 0) begin
        rx_stall <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      rx_stall <= 1'b0;
      @(posedge clk_i);
      while (!(out_valid && !out_stall)) @(posedge clk_i);
      taken++;
    end
  end

  // one long back-pressure stretch while the sender keeps offering items
  initial begin : hold_off
    wait (items_sent >= HoldAfter);
    @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  initial begin : stimulus
    logic [31:0] mpt_val, hpt_val;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values: first item latches only, then wrap edges
    push_counts(16'd1000, 16'd2000);
    push_counts(16'd1000, 16'd2000);
    push_counts(16'd1100, 16'd2100);
    push_counts(16'd1050, 16'd2150);
    push_counts(16'd0, 16'd0);
    push_counts(16'd65535, 16'd65535);
    push_counts(16'd0, 16'd0);
    push_counts(16'd60000, 16'd0);
    push_counts(16'd0, 16'd60001);
    push_counts(16'd60001, 16'd0);
    settle();

    // largest gains: travel saturation on either side of the limit
    program_regs(32'hFFFF_FFFF, 32'h00FF_FFFF);
    push_counts(16'd0, 16'd0);
    push_counts(16'd60000, 16'd60000);
    push_counts(16'd0, 16'd0);
    push_counts(16'd32768, 16'd32768);
    push_counts(16'd0, 16'd0);
    push_counts(16'd32768, 16'd32769);
    push_counts(16'd65535, 16'd0);
    settle();

    // zero gains: pose must not move
    program_regs(32'd0, 32'd0);
    push_counts(16'd1000, 16'd5000);
    push_counts(16'd65535, 16'd65535);
    settle();

    for (int ph = 0; ph < RandomPhases; ph++) begin
      case ($urandom_range(0, 3))
        0:       mpt_val = 32'd0;
        1:       mpt_val = 32'hFFFF_FFFF;
        2:       mpt_val = MptDefault;
        default: mpt_val = $urandom;
      endcase
      // upper byte of the heading gain is don't-care, toggle it anyway
      case ($urandom_range(0, 3))
        0:       hpt_val = {8'($urandom), 24'd0};
        1:       hpt_val = {8'($urandom), 24'hFF_FFFF};
        2:       hpt_val = HptDefault;
        default: hpt_val = $urandom;
      endcase
      program_regs(mpt_val, hpt_val);
      repeat (PhaseItems) push_random();
      settle();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> differential_drive_odometry.f
+incdir+rtl/core
rtl/core/ddo_pkg.sv
rtl/core/ddo_cordic.sv
rtl/core/ddo_dpath.sv
rtl/core/ddo_ctrl.sv
rtl/core/differential_drive_odometry.sv
rtl/core/ddo_checker.sv
dv/odometry_checker.sv
dv/testbench.sv
